// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside of reset.
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// Condition that must never hold at a rising clock edge outside of reset.
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) else $error(msg);

`endif

// ===== design/lds_pkg.sv =====
`timescale 1ns / 1ps

package lds_pkg;

    localparam int LDS_BRIGHTNESS_MAX = 7;
    localparam int LDS_DIGITS         = 4;

    localparam int LDS_IN_DATA_W  = 40;
    localparam int LDS_IN_USER_W  = 2;
    localparam int LDS_OUT_DATA_W = 8;
    localparam int LDS_OUT_USER_W = 2;
    localparam int LDS_SEGS       = 4;
    localparam int LDS_QUEUE_DEPTH = 2;

    localparam logic [7:0] CMD_AUTO_INC = 8'h40;
    localparam logic [7:0] CMD_ADDRESS  = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY  = 8'h88;

    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_BRIGHT   = 2'd1;
    localparam logic [1:0] MODE_SEGMENTS = 2'd2;

    typedef enum logic [1:0] {
        STATUS_TICK       = 2'd0,
        STATUS_ACCEPTED   = 2'd1,
        STATUS_BAD_BRIGHT = 2'd2,
        STATUS_BUSY       = 2'd3
    } lds_status_t;

    typedef enum logic [1:0] {
        STAGE_START = 2'd0,
        STAGE_BYTE  = 2'd1,
        STAGE_STOP  = 2'd2
    } lds_stage_t;

    // One classified request as it travels from the front end to the sequencer.
    typedef struct packed {
        logic                  start;
        logic                  is_seg;
        logic [7:0]            cmd;
        logic [LDS_SEGS-1:0][7:0] segs;
        lds_status_t           status;
    } lds_item_t;

endpackage

// ===== design/lds_front.sv =====
`timescale 1ns / 1ps

module lds_front #(
    parameter int BRIGHTNESS_MAX = lds_pkg::LDS_BRIGHTNESS_MAX,
    parameter int DIGITS         = lds_pkg::LDS_DIGITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lds_pkg::LDS_IN_DATA_W-1:0]  s_tdata,
    input  logic [lds_pkg::LDS_IN_USER_W-1:0]  s_tuser,
    output logic                               push_valid,
    input  logic                               push_ready,
    output lds_pkg::lds_item_t                 push_item
);
    import lds_pkg::*;

    // Slot counts of a whole sequence: a frame is two start slots, eighteen
    // slots per byte and four stop slots.
    localparam int LEN_BRIGHT = 2 + 18 + 4;
    localparam int LEN_SEG    = LEN_BRIGHT + 2 + 18 * (1 + DIGITS) + 4;
    localparam int CNT_W      = $clog2(LEN_SEG);

    logic [CNT_W-1:0] remain_reg;
    logic [CNT_W-1:0] remain_next;
    logic             accept;
    logic [7:0]       bright;
    lds_item_t        item;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;
    assign bright     = s_tdata[7:0];
    assign push_item  = item;

    always_comb
    begin
        item        = '0;
        item.segs   = s_tdata[39:8];
        item.status = STATUS_TICK;
        if (remain_reg != '0)
        begin
            if (s_tuser == MODE_BRIGHT || s_tuser == MODE_SEGMENTS)
            begin
                item.status = STATUS_BUSY;
            end
        end
        else
        begin
            case (s_tuser)
                MODE_BRIGHT:
                begin
                    if (bright > 8'(BRIGHTNESS_MAX))
                    begin
                        item.status = STATUS_BAD_BRIGHT;
                    end
                    else
                    begin
                        item.status = STATUS_ACCEPTED;
                        item.start  = 1'b1;
                        item.cmd    = CMD_DISPLAY | bright;
                    end
                end
                MODE_SEGMENTS:
                begin
                    item.status = STATUS_ACCEPTED;
                    item.start  = 1'b1;
                    item.is_seg = 1'b1;
                    item.cmd    = CMD_AUTO_INC;
                end
                default:
                begin
                    item.status = STATUS_TICK;
                end
            endcase
        end
    end

    // The request that starts a sequence drives its first slot, so the count
    // holds the slots that are still to come.
    always_comb
    begin
        remain_next = remain_reg;
        if (accept)
        begin
            if (item.start)
            begin
                remain_next = item.is_seg ? CNT_W'(LEN_SEG - 1) : CNT_W'(LEN_BRIGHT - 1);
            end
            else if (remain_reg != '0)
            begin
                remain_next = remain_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
        end
        else
        begin
            remain_reg <= remain_next;
        end
    end

endmodule

// ===== design/lds_queue.sv =====
`timescale 1ns / 1ps

module lds_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  lds_pkg::lds_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output lds_pkg::lds_item_t pop_item
);
    import lds_pkg::*;

    localparam int PTR_W = (LDS_QUEUE_DEPTH > 1) ? $clog2(LDS_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(LDS_QUEUE_DEPTH + 1);

    lds_item_t        entry_reg [LDS_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(LDS_QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(LDS_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(LDS_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/lds_back.sv =====
`timescale 1ns / 1ps

module lds_back #(
    parameter int DIGITS = lds_pkg::LDS_DIGITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  lds_pkg::lds_item_t                 pop_item,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lds_pkg::LDS_OUT_DATA_W-1:0] m_tdata,
    output logic [lds_pkg::LDS_OUT_USER_W-1:0] m_tuser,
    output logic                               m_tlast
);
    import lds_pkg::*;

    localparam logic [2:0] BYTES_SEG = 3'(1 + DIGITS);

    lds_stage_t           stage_reg, stage_next, stage_eff;
    logic [4:0]           phase_reg, phase_next, phase_eff;
    logic [7:0]           shift_reg, shift_next;
    logic [2:0]           bidx_reg, bidx_next, bidx_eff, bidx_inc;
    logic                 frame_reg, frame_next, frame_eff;
    logic [7:0]           cmd_reg, cmd_next;
    logic [LDS_SEGS-1:0][7:0] segs_reg, segs_next;
    logic                 clk_lat_reg, clk_lat_next;
    logic                 dio_lat_reg, dio_lat_next;
    logic                 active_reg, active_next, active_eff;
    logic                 driven, more, done;
    logic [2:0]           bytes_in_frame;
    logic                 step;

    logic                 out_valid_reg;
    logic [3:0]           out_data_reg;
    lds_status_t          out_status_reg;
    logic                 out_last_reg;

    function automatic logic [7:0] frame_byte(
        input logic                     frame,
        input logic [2:0]               idx,
        input logic [7:0]               cmd,
        input logic [LDS_SEGS-1:0][7:0] segs
    );
        logic [2:0] sel;
        sel = idx - 3'd1;
        if (!frame)
        begin
            return cmd;
        end
        else if (idx == 3'd0)
        begin
            return CMD_ADDRESS;
        end
        else if (!sel[2])
        begin
            return segs[sel[1:0]];
        end
        else
        begin
            return 8'h00;
        end
    endfunction

    assign pop_ready = !out_valid_reg || m_tready;
    assign step      = pop_valid && pop_ready;

    always_comb
    begin
        // A starting command restarts the sequence; its own slot is the first.
        if (pop_item.start)
        begin
            stage_eff  = STAGE_START;
            phase_eff  = '0;
            bidx_eff   = '0;
            frame_eff  = 1'b0;
            cmd_next   = pop_item.cmd;
            active_eff = 1'b1;
            segs_next  = pop_item.is_seg ? pop_item.segs : segs_reg;
        end
        else
        begin
            stage_eff  = stage_reg;
            phase_eff  = phase_reg;
            bidx_eff   = bidx_reg;
            frame_eff  = frame_reg;
            cmd_next   = cmd_reg;
            active_eff = active_reg;
            segs_next  = segs_reg;
        end

        stage_next     = stage_eff;
        phase_next     = phase_eff;
        bidx_next      = bidx_eff;
        frame_next     = frame_eff;
        shift_next     = shift_reg;
        clk_lat_next   = clk_lat_reg;
        dio_lat_next   = dio_lat_reg;
        active_next    = active_eff;
        driven         = 1'b1;
        more           = 1'b0;
        done           = 1'b0;
        bidx_inc       = bidx_eff + 3'd1;
        bytes_in_frame = frame_eff ? BYTES_SEG : 3'd1;

        if (active_eff)
        begin
            more = 1'b1;
            case (stage_eff)
                STAGE_START:
                begin
                    clk_lat_next = 1'b1;
                    dio_lat_next = (phase_eff == 5'd0);
                    if (phase_eff >= 5'd1)
                    begin
                        stage_next = STAGE_BYTE;
                        phase_next = '0;
                        bidx_next  = '0;
                        shift_next = frame_byte(frame_eff, 3'd0, cmd_next, segs_next);
                    end
                    else
                    begin
                        phase_next = phase_eff + 5'd1;
                    end
                end
                STAGE_BYTE:
                begin
                    clk_lat_next = phase_eff[0];
                    if (phase_eff < 5'd16)
                    begin
                        dio_lat_next = shift_reg[phase_eff[3:1]];
                    end
                    else
                    begin
                        driven = 1'b0;
                    end
                    if (phase_eff >= 5'd17)
                    begin
                        phase_next = '0;
                        bidx_next  = bidx_inc;
                        if (bidx_inc < bytes_in_frame)
                        begin
                            shift_next = frame_byte(frame_eff, bidx_inc, cmd_next, segs_next);
                        end
                        else
                        begin
                            stage_next = STAGE_STOP;
                        end
                    end
                    else
                    begin
                        phase_next = phase_eff + 5'd1;
                    end
                end
                STAGE_STOP:
                begin
                    case (phase_eff)
                        5'd0:    clk_lat_next = 1'b0;
                        5'd1:    dio_lat_next = 1'b0;
                        5'd2:    clk_lat_next = 1'b1;
                        default: dio_lat_next = 1'b1;
                    endcase
                    if (phase_eff >= 5'd3)
                    begin
                        phase_next = '0;
                        if (cmd_next == CMD_AUTO_INC && !frame_eff)
                        begin
                            frame_next = 1'b1;
                            stage_next = STAGE_START;
                        end
                        else
                        begin
                            active_next = 1'b0;
                            done        = 1'b1;
                            more        = 1'b0;
                        end
                    end
                    else
                    begin
                        phase_next = phase_eff + 5'd1;
                    end
                end
                default:
                begin
                    stage_next = STAGE_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= STAGE_START;
            phase_reg     <= '0;
            shift_reg     <= '0;
            bidx_reg      <= '0;
            frame_reg     <= 1'b0;
            cmd_reg       <= '0;
            clk_lat_reg   <= 1'b0;
            dio_lat_reg   <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                stage_reg   <= stage_next;
                phase_reg   <= phase_next;
                shift_reg   <= shift_next;
                bidx_reg    <= bidx_next;
                frame_reg   <= frame_next;
                cmd_reg     <= cmd_next;
                clk_lat_reg <= clk_lat_next;
                dio_lat_reg <= dio_lat_next;
                active_reg  <= active_next;
            end
            if (pop_ready)
            begin
                out_valid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            segs_reg       <= segs_next;
            out_data_reg   <= {more, driven, driven & dio_lat_next, clk_lat_next};
            out_status_reg <= pop_item.status;
            out_last_reg   <= done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(LDS_OUT_DATA_W - 4){1'b0}}, out_data_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/led_display_two_wire_sender_core.sv =====
`timescale 1ns / 1ps

// Serial sender for a two-wire LED display driver. Every input request is one
// delay slot and returns exactly one result that gives the clock and data line
// levels for that slot, whether the data line is driven or released for the
// acknowledge, whether the sequence goes on, a status and, on tlast, the final
// slot of a sequence. A brightness request (tuser 1) starts a 24-slot frame
// carrying 0x88 or the level, unless the level is above BRIGHTNESS_MAX; a
// segment request (tuser 2) starts a 0x40 frame followed by a 0xC0 frame with
// DIGITS segment bytes, 48 + 18 * DIGITS slots in all. Requests that start a
// command while a sequence runs are answered with the busy status and act as
// plain ticks. The front end classifies each request against its own count of
// remaining slots and hands it through a two-entry queue to the slot
// sequencer, which owns the output register. One request is taken every clock
// cycle while the result side keeps up. A request is written into the queue at
// the edge that takes it and the output register loads its result when the
// sequencer pops it from the queue, so each result passes through the queue
// entry and the output register before it is offered.
module led_display_two_wire_sender_core #(
    parameter int BRIGHTNESS_MAX = lds_pkg::LDS_BRIGHTNESS_MAX,
    parameter int DIGITS         = lds_pkg::LDS_DIGITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // brightness [7:0], seg0 [15:8], seg1 [23:16], seg2 [31:24], seg3 [39:32]
    input  logic [lds_pkg::LDS_IN_DATA_W-1:0]  s_tdata,
    // mode [1:0]
    input  logic [lds_pkg::LDS_IN_USER_W-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // clk_level [0], dio_level [1], dio_driven [2], busy_res [3], zero [7:4]
    output logic [lds_pkg::LDS_OUT_DATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [lds_pkg::LDS_OUT_USER_W-1:0] m_tuser,
    // seq_done
    output logic                               m_tlast
);
    import lds_pkg::*;

    logic      push_valid;
    logic      push_ready;
    lds_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    lds_item_t pop_item;

    // The front end tracks the remaining slots itself, so it can decide busy
    // status without waiting on the sequencer.
    lds_front #(
        .BRIGHTNESS_MAX (BRIGHTNESS_MAX),
        .DIGITS         (DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    lds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // The sequencer steps the frame state once per request and registers the
    // line levels of that slot.
    lds_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== design/lds_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lds_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [lds_pkg::LDS_IN_DATA_W-1:0]  s_tdata,
    input logic [lds_pkg::LDS_IN_USER_W-1:0]  s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [lds_pkg::LDS_OUT_DATA_W-1:0] m_tdata,
    input logic [lds_pkg::LDS_OUT_USER_W-1:0] m_tuser,
    input logic                               m_tlast
);
    import lds_pkg::*;

    logic stalled;
    assign stalled = m_tvalid && !m_tready;

    `ASSERT_IMPLIES(a_out_hold, clk, rst_n, stalled |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")
    `ASSERT_NEVER(a_done_not_busy, clk, rst_n, m_tvalid && m_tlast && m_tdata[3], "final slot still reports busy")
    `ASSERT_NEVER(a_released_low, clk, rst_n, m_tvalid && !m_tdata[2] && m_tdata[1], "released data line reported high")
    `ASSERT_IMPLIES(a_start_busy, clk, rst_n, m_tvalid && m_tuser == STATUS_ACCEPTED |-> m_tdata[3] && !m_tlast, "accepted command did not start a sequence")
    `ASSERT_IMPLIES(a_reject_idle, clk, rst_n, m_tvalid && m_tuser == STATUS_BAD_BRIGHT |-> !m_tdata[3] && m_tdata[2] && !m_tlast, "rejected brightness disturbed the link")

endmodule

bind led_display_two_wire_sender_core lds_checker u_lds_checker (.*);
